// ===== src/wbps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern search block.
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int MAX_PATTERN  = 32;
   localparam int OFFSET_BITS  = 32;
   localparam int PATTERN_REGS = 4;
   localparam int LEN_W        = 6;
   localparam int IDX_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int FILL_W       = $clog2(MAX_PATTERN + 1);
   localparam int ADDR_W       = 64;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_0    = 3'd0,
      CSR_PATTERN_1    = 3'd1,
      CSR_PATTERN_2    = 3'd2,
      CSR_PATTERN_3    = 3'd3,
      CSR_CARE_MASK    = 3'd4,
      CSR_PATTERN_LEN  = 3'd5,
      CSR_BASE_ADDRESS = 3'd6
   } csr_index_type;

   // clamp the programmed length into 1..MAX_PATTERN
   function automatic logic [LEN_W-1:0] active_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] res;
      res = len;
      if (len == '0) begin
         res = LEN_W'(1);
      end else if (len > LEN_W'(MAX_PATTERN)) begin
         res = LEN_W'(MAX_PATTERN);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== src/wbps_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_if
// Handshake channels of the wildcard byte pattern search block.
// ----------------------------------------------------------------------------
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [63:0] match_address;
   modport source (output valid, output found, output match_address, input ready);
   modport sink   (input valid, input found, input match_address, output ready);
endinterface

interface wbps_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/wildcard_byte_pattern_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search
// Streams a buffer one byte per item and reports the first masked match of
// the programmed pattern, or a miss at the end of the buffer.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                       | handshake
//  ---------+-----+-------------------------------+------------
//  req_ch   | in  | data_byte[7:0], last_byte     | valid/ready
//  rsp_ch   | out | found, match_address[63:0]    | valid/ready
//  csr_ch   | in  | index[2:0], data[63:0]        | valid/ready (ready tied high)
//
//  One item per cycle while the skid entry is empty: the window shift and the
//  32-lane masked compare sit between the byte window and the result register.
//  A result register plus one skid entry lets input flow while rsp stalls;
//  req ready drops only when the skid entry is occupied.
//  Synchronous active-high reset restores register defaults and clears scan.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search
   import wbps_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   wbps_req_if.sink    req_ch,
   wbps_rsp_if.source  rsp_ch,
   wbps_csr_if.sink    csr_ch
);

   // configuration
   logic [CSR_DATA_W-1:0]  pattern_ff [PATTERN_REGS];
   logic [MAX_PATTERN-1:0] care_ff;
   logic [LEN_W-1:0]       length_ff;
   logic [ADDR_W-1:0]      base_ff;

   // scan state
   logic [7:0]             window_ff [MAX_PATTERN];
   logic [7:0]             window_in [MAX_PATTERN];
   logic [FILL_W-1:0]      fill_ff;
   logic [FILL_W-1:0]      fill_in;
   logic [OFFSET_BITS-1:0] seen_ff;
   logic [OFFSET_BITS-1:0] seen_in;
   logic                   reported_ff;

   // result register and skid entry
   logic              out_valid_ff;
   logic              out_found_ff;
   logic [ADDR_W-1:0] out_addr_ff;
   logic              skid_valid_ff;
   logic              skid_found_ff;
   logic [ADDR_W-1:0] skid_addr_ff;

   logic [7:0]             pat_byte [MAX_PATTERN];
   logic [LEN_W-1:0]       len;
   logic                   accept;
   logic                   hit;
   logic                   res_valid;
   logic [OFFSET_BITS-1:0] start_off;
   logic [ADDR_W-1:0]      res_addr;
   logic                   out_free;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < PATTERN_REGS; r++) begin
            pattern_ff[r] <= '0;
         end
         care_ff   <= '1;
         length_ff <= LEN_W'(1);
         base_ff   <= '0;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_PATTERN_0:    pattern_ff[0] <= csr_ch.data;
            CSR_PATTERN_1:    pattern_ff[1] <= csr_ch.data;
            CSR_PATTERN_2:    pattern_ff[2] <= csr_ch.data;
            CSR_PATTERN_3:    pattern_ff[3] <= csr_ch.data;
            CSR_CARE_MASK:    care_ff       <= csr_ch.data[MAX_PATTERN-1:0];
            CSR_PATTERN_LEN:  length_ff     <= csr_ch.data[LEN_W-1:0];
            CSR_BASE_ADDRESS: base_ff       <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pat_byte[j] = pattern_ff[j / 8][8 * (j % 8) +: 8];
      end
   end

   assign len    = active_len(length_ff);
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      window_in[0] = req_ch.data_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         window_in[k] = window_ff[k - 1];
      end
   end

   assign fill_in = (fill_ff == FILL_W'(MAX_PATTERN)) ? fill_ff : fill_ff + FILL_W'(1);
   assign seen_in = seen_ff + OFFSET_BITS'(1);

   // window lane k holds the byte k steps old; it meets pattern byte len-1-k
   always_comb begin
      logic [IDX_W-1:0] j;
      hit = (fill_in >= FILL_W'(len));
      for (int k = 0; k < MAX_PATTERN; k++) begin
         j = IDX_W'(len - LEN_W'(1) - LEN_W'(k));
         if ((LEN_W'(k) < len) && care_ff[j] && (window_in[k] != pat_byte[j])) begin
            hit = 1'b0;
         end
      end
   end

   assign start_off = seen_in - OFFSET_BITS'(len);
   assign res_addr  = hit ? (base_ff + ADDR_W'(start_off)) : '0;
   assign res_valid = accept && !reported_ff && (hit || req_ch.last_byte);

   always_ff @(posedge clock) begin
      if (accept && !reported_ff) begin
         for (int k = 0; k < MAX_PATTERN; k++) begin
            window_ff[k] <= window_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (accept) begin
         if (req_ch.last_byte) begin
            fill_ff     <= '0;
            seen_ff     <= '0;
            reported_ff <= 1'b0;
         end else if (!reported_ff) begin
            fill_ff     <= fill_in;
            seen_ff     <= seen_in;
            reported_ff <= hit;
         end
      end
   end

   assign req_ch.ready = !skid_valid_ff;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            // drain skid first; no item is taken while it is full
            out_valid_ff  <= 1'b1;
            out_found_ff  <= skid_found_ff;
            out_addr_ff   <= skid_addr_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= res_valid;
            out_found_ff <= hit;
            out_addr_ff  <= res_addr;
         end
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
         skid_found_ff <= hit;
         skid_addr_ff  <= res_addr;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.found         = out_found_ff;
   assign rsp_ch.match_address = out_addr_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while result register empty");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_PATTERN))
      else $error("window fill count out of range");

   a_hit_sets_reported: assert property (@(posedge clock) disable iff (reset)
      (accept && !reported_ff && hit && !req_ch.last_byte) |=> reported_ff)
      else $error("match did not mark buffer as reported");

   a_no_result_after_match: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> !res_valid)
      else $error("second result produced for one buffer");

   a_miss_address_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_found_ff) |-> (out_addr_ff == '0))
      else $error("miss reported with nonzero address");

endmodule
`default_nettype wire
